[rtl/core/smrq_pkg.sv]
`timescale 1ns / 1ps

package smrq_pkg;

  localparam int CapacityLog2 = 10;
  localparam int Capacity     = 1 << CapacityLog2;
  localparam int CntW         = CapacityLog2 + 1;
  localparam int ValW         = 32;
  localparam int FieldCntW    = 11;
  localparam int OutDataW     = 24;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  typedef struct packed {
    logic                   vld;
    action_t                act;
    logic signed [ValW-1:0] value;
    logic [CntW-1:0]        held;     // insert: target slot; query: values held
    logic [CntW-1:0]        total;
    logic                   dropped;
    logic [CntW-1:0]        rank;
  } token_t;

endpackage

[rtl/core/sorted_multiset_rank_query.sv]
`timescale 1ns / 1ps
// The transaction walks the row of value cells from input to result, one
// cell per cycle while the row is not stalled.
// Throughput: one transaction per cycle; the whole row stalls while the
// result at the end of the row is not taken.
// Reset: synchronous, active low; clears the value count and all in-flight
// transactions. Stored values need no clearing.

module sorted_multiset_rank_query (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [smrq_pkg::ValW-1:0]         in_tdata,   // [31:0] value
  input  logic                              in_tuser,   // [0] action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [smrq_pkg::OutDataW-1:0]     out_tdata   // [10:0] rank,
                                                        // [21:11] stored_total,
                                                        // [22] dropped, [23] zero
);

  logic                        adv;
  logic [smrq_pkg::CntW-1:0]   count_r;
  logic [smrq_pkg::CntW-1:0]   count_nxt;
  logic                        full;
  smrq_pkg::token_t            tok [0:smrq_pkg::Capacity];
  smrq_pkg::token_t            head;
  smrq_pkg::token_t            tail;

  assign tail      = tok[smrq_pkg::Capacity];
  assign adv       = !tail.vld || out_tready;
  assign in_tready = adv;
  assign full      = count_r == smrq_pkg::CntW'(smrq_pkg::Capacity);

  always_comb begin
    count_nxt    = count_r;
    head.vld     = in_tvalid;
    head.act     = smrq_pkg::action_t'(in_tuser);
    head.value   = $signed(in_tdata);
    head.held    = count_r;
    head.total   = count_r;
    head.dropped = 1'b0;
    head.rank    = '0;
    if (head.act == smrq_pkg::ACT_INSERT) begin
      if (full) begin
        head.dropped = 1'b1;
      end else begin
        count_nxt  = count_r + smrq_pkg::CntW'(1);
        head.total = count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_tvalid && in_tready) begin
      count_r <= count_nxt;
    end
  end

  assign tok[0] = head;

  for (genvar i = 0; i < smrq_pkg::Capacity; i++) begin : g_cell
    smrq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .slot    (smrq_pkg::CntW'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign out_tvalid = tail.vld;
  assign out_tdata  = {1'b0, tail.dropped,
                       smrq_pkg::FieldCntW'(tail.total),
                       smrq_pkg::FieldCntW'(tail.rank)};

endmodule

[rtl/core/smrq_cell.sv]
`timescale 1ns / 1ps

module smrq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [smrq_pkg::CntW-1:0]       slot,
  input  smrq_pkg::token_t                tok_in,
  output smrq_pkg::token_t                tok_out
);

  logic signed [smrq_pkg::ValW-1:0] value_r;
  smrq_pkg::token_t                 tok_r;
  smrq_pkg::token_t                 tok_nxt;
  logic                             occupied;
  logic                             hit;
  logic                             wr;

  assign occupied = slot < tok_in.held;
  assign hit      = occupied && (value_r < $signed(tok_in.value));
  assign wr       = en && tok_in.vld && (tok_in.act == smrq_pkg::ACT_INSERT) &&
                    !tok_in.dropped && (tok_in.held == slot);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.act == smrq_pkg::ACT_QUERY && hit) begin
      tok_nxt.rank = tok_in.rank + smrq_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      value_r <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.act     <= tok_nxt.act;
      tok_r.value   <= tok_nxt.value;
      tok_r.held    <= tok_nxt.held;
      tok_r.total   <= tok_nxt.total;
      tok_r.dropped <= tok_nxt.dropped;
      tok_r.rank    <= tok_nxt.rank;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/core/smrq_checker.sv]
`timescale 1ns / 1ps

module smrq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_drop_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tdata[10:0] == 11'd0 &&
    out_tdata[21:11] == 11'd1024)
    else $error("dropped insert with rank or not full");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:0] <= out_tdata[21:11])
    else $error("rank above stored total");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

endmodule

bind sorted_multiset_rank_query smrq_checker u_smrq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import smrq_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 6;
  localparam int RandomItems = 930;
  localparam int HoldAfter   = 300;
  localparam int HoldCycles  = 3000;
  localparam int DrainCycles = Capacity + 100;
  localparam int CycleLimit  = 500000;

  typedef struct {
    action_t                act;
    logic signed [ValW-1:0] value;
  } multiset_op_t;

  typedef struct {
    logic [FieldCntW-1:0] rank;
    logic [FieldCntW-1:0] total;
    logic                 dropped;
  } rank_result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [ValW-1:0]     in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  multiset_op_t           pending_ops[$];
  rank_result_t           awaited_results[$];
  logic signed [ValW-1:0] held_values[Capacity];
  int                     held_count     = 0;
  int                     planned_fill   = 0;
  int                     mismatch_count = 0;
  int                     taken_count    = 0;
  int                     gap_left       = 0;
  int                     calm_left      = 0;
  int                     stall_left     = 0;
  int                     steady_left    = 0;
  int                     hold_left      = 0;
  bit                     hold_done      = 1'b0;
  longint                 cycle_count    = 0;
  multiset_op_t           next_op;
  rank_result_t           want;

  sorted_multiset_rank_query uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #HalfPeriod clk = ~clk;

  function automatic rank_result_t apply_to_multiset(action_t act,
                                                     logic signed [ValW-1:0] value);
    rank_result_t res;
    int           below;
    below       = 0;
    res.dropped = 1'b0;
    if (act == ACT_INSERT) begin
      if (held_count < Capacity) begin
        held_values[held_count] = value;
        held_count++;
      end else begin
        res.dropped = 1'b1;
      end
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (held_values[i] < value) below++;
      end
    end
    res.rank  = FieldCntW'(below);
    res.total = FieldCntW'(held_count);
    return res;
  endfunction

  // mostly no gap or short gaps, rare long ones, occasional runs with none
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return 0;
      12, 13, 14, 15, 16, 17, 18: return $urandom_range(1, 3);
      default: return $urandom_range(10, 40);
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int offset;
    offset = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h8000_0001;
          2: return 32'h7fff_fffe;
          default: return 32'h7fff_ffff;
        endcase
      end
      1, 2, 3: return ValW'(offset - 8);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(action_t act, logic [ValW-1:0] value);
    multiset_op_t op;
    op.act   = act;
    op.value = value;
    pending_ops.push_back(op);
    if (act == ACT_INSERT && planned_fill < Capacity) planned_fill++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_to_multiset(action_t'(in_tuser), in_tdata));
        taken_count <= taken_count + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_op.value;
          in_tuser  <= next_op.act;
          gap_left = pick_gap(calm_left);
        end
      end
    end
  end

  // long receiver hold-off so the row fills and backs up into the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && taken_count >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected transaction: %h", out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[10:0] !== want.rank || out_tdata[21:11] !== want.total ||
              out_tdata[22] !== want.dropped || out_tdata[23] !== 1'b0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: exp rank %0d total %0d dropped %0d, ",
                        "got rank %0d total %0d dropped %0d pad %b"},
                       want.rank, want.total, want.dropped, out_tdata[10:0],
                       out_tdata[21:11], out_tdata[22], out_tdata[23]);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(steady_left);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int insert_pct;
    int total_ops;
    // empty store, extremes, duplicates
    add_op(ACT_QUERY,  32'h0000_0000);
    add_op(ACT_QUERY,  32'h8000_0000);
    add_op(ACT_INSERT, 32'h8000_0000);
    add_op(ACT_INSERT, 32'h7fff_ffff);
    add_op(ACT_INSERT, 32'h0000_0000);
    add_op(ACT_INSERT, 32'hffff_ffff);
    add_op(ACT_INSERT, 32'h0000_0001);
    add_op(ACT_INSERT, 32'h0000_0005);
    add_op(ACT_INSERT, 32'h0000_0005);
    add_op(ACT_INSERT, 32'h0000_0005);
    add_op(ACT_QUERY,  32'h8000_0000);
    add_op(ACT_QUERY,  32'h8000_0001);
    add_op(ACT_QUERY,  32'h7fff_ffff);
    add_op(ACT_QUERY,  32'h7fff_fffe);
    add_op(ACT_QUERY,  32'h0000_0005);
    add_op(ACT_QUERY,  32'h0000_0006);
    add_op(ACT_QUERY,  32'h0000_0000);
    add_op(ACT_QUERY,  32'hffff_ffff);
    add_op(ACT_QUERY,  32'haaaa_5555);
    add_op(ACT_QUERY,  32'h5555_aaaa);
    // mostly inserts; too few to fill the store, so none is refused
    for (int n = 0; n < RandomItems; n++) begin
      insert_pct = (planned_fill < Capacity) ? 93 : 35;
      if ($urandom_range(0, 99) < insert_pct) add_op(ACT_INSERT, pick_value());
      else add_op(ACT_QUERY, pick_value());
    end
    total_ops = pending_ops.size();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    while (taken_count < total_ops || awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sorted_multiset_rank_query.f]
rtl/core/smrq_pkg.sv
rtl/core/smrq_cell.sv
rtl/core/sorted_multiset_rank_query.sv
rtl/core/smrq_checker.sv
tb/sv/testbench.sv
